// ===== rtl/ghp_pkg.sv =====
`default_nettype none
package ghp_pkg;

	// sizes
	localparam int COUNT_BITS = 24;
	localparam int NUM_BINS   = 256;
	localparam int BIN_BITS   = $clog2(NUM_BINS);
	localparam int OUT_BITS   = 24;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// command codes on the mode field
	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// classified operation carried through the queue
	typedef enum logic [1:0] {
		OP_ADD,
		OP_READ,
		OP_CLEAR
	} op_t;

	// back end sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	// input transaction
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] bin_index;
	} pixel_t;

	// result transaction
	typedef struct packed {
		logic [OUT_BITS-1:0] bin_count;
		logic [7:0]          gray_level;
		logic [OUT_BITS-1:0] peak_count;
	} result_t;

	// queue entry between front and back
	typedef struct packed {
		op_t                op;
		logic [BIN_BITS-1:0] level;
	} entry_t;

	// fit a count into the result field width
	function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[OUT_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ghp_ram.sv =====
`default_nettype none
module ghp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ghp_front.sv =====
`default_nettype none
module ghp_front (
	input  wire logic            pixel_valid,
	output logic                 pixel_stall,
	input  wire ghp_pkg::pixel_t pixel,
	output logic                 push_valid,
	output ghp_pkg::entry_t      push_entry,
	input  wire logic            full
);
	import ghp_pkg::*;

	logic [12:0] luma_sum;

	// weighted luma sum, at most 32 * 255
	assign luma_sum = 13'(pixel.red) * 13'd11 + 13'(pixel.green) * 13'd16
		+ 13'(pixel.blue) * 13'd5;

	// classify the command, unused code behaves as a read
	always_comb begin
		push_entry = '0;
		unique case (pixel.mode)
			MODE_ADD: begin
				push_entry.op    = OP_ADD;
				push_entry.level = luma_sum[12:5];
			end
			MODE_CLEAR: begin
				push_entry.op    = OP_CLEAR;
				push_entry.level = '0;
			end
			default: begin
				push_entry.op    = OP_READ;
				push_entry.level = pixel.bin_index;
			end
		endcase
	end

	// hand over to the queue
	assign pixel_stall = full;
	assign push_valid  = pixel_valid;

endmodule
`default_nettype wire

// ===== rtl/ghp_queue.sv =====
`default_nettype none
module ghp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	input  wire ghp_pkg::entry_t push_entry,
	output logic                 full,
	input  wire logic            pop,
	output ghp_pkg::entry_t      head,
	output logic                 empty
);
	import ghp_pkg::*;

	entry_t     entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push_valid && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ghp_back.sv =====
`default_nettype none
module ghp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            empty,
	input  wire ghp_pkg::entry_t head,
	output logic                 pop,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output ghp_pkg::result_t     result
);
	import ghp_pkg::*;

	back_state_t           state_q;
	back_state_t           state_nxt;
	op_t                   op_s1;
	logic [BIN_BITS-1:0]   level_s1;
	logic                  hit_s1;
	logic [NUM_BINS-1:0]   valid_q;
	logic [COUNT_BITS-1:0] peak_q;
	logic                  out_valid_q;
	result_t               out_q;
	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] cur_count;
	logic [COUNT_BITS-1:0] add_count;
	logic [COUNT_BITS-1:0] peak_nxt;
	logic                  out_free;
	logic                  wr_en;
	result_t               res_nxt;

	// bin counts
	ghp_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_BINS)
	) u_bins (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(level_s1),
		.wr_data(add_count),
		.rd_en  (pop),
		.rd_addr(head.level),
		.rd_data(rd_data)
	);

	// output slot is free by the time the execute cycle comes round
	assign out_free = !out_valid_q || !result_stall;

	// bin value with never-written bins reading as zero, saturating increment
	assign cur_count = hit_s1 ? rd_data : '0;
	assign add_count = (cur_count == COUNT_MAX) ? cur_count
		: cur_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
	assign peak_nxt  = (add_count > peak_q) ? add_count : peak_q;

	// sequencer: issue read, then execute
	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		wr_en     = 1'b0;
		res_nxt   = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty && out_free) begin
					pop       = 1'b1;
					state_nxt = BK_EXEC;
				end
			end
			BK_EXEC: begin
				state_nxt = BK_IDLE;
				case (op_s1)
					OP_ADD: begin
						wr_en              = 1'b1;
						res_nxt.bin_count  = to_out(add_count);
						res_nxt.gray_level = level_s1;
						res_nxt.peak_count = to_out(peak_nxt);
					end
					OP_CLEAR: begin
						res_nxt = '0;
					end
					default: begin
						res_nxt.bin_count  = to_out(cur_count);
						res_nxt.gray_level = level_s1;
						res_nxt.peak_count = to_out(peak_q);
					end
				endcase
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// command held for the execute cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1    <= head.op;
			level_s1 <= head.level;
			hit_s1   <= valid_q[head.level];
		end
	end

	// per-bin written flags and running peak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			peak_q  <= '0;
		end else if (state_q == BK_EXEC) begin
			if (op_s1 == OP_CLEAR) begin
				valid_q <= '0;
				peak_q  <= '0;
			end else if (op_s1 == OP_ADD) begin
				valid_q[level_s1] <= 1'b1;
				peak_q            <= peak_nxt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == BK_EXEC) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_EXEC) begin
			out_q <= res_nxt;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EXEC) |-> !(out_valid_q && result_stall))
		else $error("result overwritten while stalled");

	// every execute cycle follows an issued read
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EXEC) |-> $past(pop))
		else $error("execute without issue");

	// peak only falls on a clear
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EXEC && op_s1 != OP_CLEAR) |=> (peak_q >= $past(peak_q)))
		else $error("peak decreased");

	// an added bin never exceeds the peak
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EXEC && op_s1 == OP_ADD) |=> (peak_q >= $past(add_count)))
		else $error("peak below updated bin");
`endif

endmodule
`default_nettype wire

// ===== rtl/gray_histogram_with_peak_top.sv =====
`default_nettype none
// a pixel passes the queue, the issue and execute states and the output register to its result
// the back end alternates issue and execute, reading then writing the bin memory per item
// a 2-entry queue lets the front keep accepting until full while the back end works or stalls
// reset: asynchronous, all bins and the peak read as zero at once through per-bin
// written flags; clear commands use the same flags, so no clearing pass is needed
module gray_histogram_with_peak_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pixel_valid,
	output logic                  pixel_stall,
	input  wire ghp_pkg::pixel_t  pixel,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output ghp_pkg::result_t      result
);
	import ghp_pkg::*;

	logic   push_valid;
	entry_t push_entry;
	logic   full;
	logic   pop;
	entry_t head;
	logic   empty;

	// classify and compute the gray level
	ghp_front u_front (
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel      (pixel),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.full       (full)
	);

	// decoupling queue
	ghp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// bin update, peak tracking and result register
	ghp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule
`default_nettype wire
